// ----- rtl/l4pc_pkg.sv -----
// Package of shared constants, codes and types for the L4 port packet classifier.
`default_nettype none

package l4pc_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 7;
    localparam int QUEUE_W  = 6;
    localparam int PORT_W   = 16;
    localparam int WORDS_W  = 4;
    localparam int LEN_W    = 8;

    // Number of queues that own a redirect socket
    localparam int QUEUE_COUNT = 64;

    // Byte offset saturation point
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = 7'd127;

    // Reset value of the match port register
    localparam logic [PORT_W-1:0] MATCH_PORT_RESET = 16'd6380;

    // EtherTypes and IP protocols
    localparam logic [15:0] TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] TYPE_CTAG = 16'h8100;
    localparam logic [15:0] TYPE_STAG = 16'h88A8;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    // Byte positions of the EtherType in untagged and tagged frames
    localparam logic [OFFSET_W-1:0] POS_TYPE_HI      = 7'd12;
    localparam logic [OFFSET_W-1:0] POS_TYPE_LO      = 7'd13;
    localparam logic [OFFSET_W-1:0] POS_TAG_TYPE_HI  = 7'd16;
    localparam logic [OFFSET_W-1:0] POS_TAG_TYPE_LO  = 7'd17;

    // Header lengths in bytes
    localparam logic [LEN_W-1:0] ETH_HDR_LEN    = 8'd14;
    localparam logic [LEN_W-1:0] TAGGED_HDR_LEN = 8'd18;
    localparam logic [LEN_W-1:0] IP_HDR_LEN     = 8'd20;
    localparam logic [LEN_W-1:0] IP_PROTO_POS   = 8'd9;
    localparam logic [LEN_W-1:0] UDP_HDR_LEN    = 8'd8;
    localparam logic [LEN_W-1:0] TCP_HDR_LEN    = 8'd20;
    localparam logic [LEN_W-1:0] DPORT_POS_HI   = 8'd2;
    localparam logic [LEN_W-1:0] DPORT_POS_LO   = 8'd3;
    localparam logic [WORDS_W-1:0] IP_WORDS_MIN = 4'd5;

    // Verdict reason codes
    typedef enum logic [2:0] {
        REASON_MATCH         = 3'd0,
        REASON_TRUNCATED     = 3'd1,
        REASON_NOT_IPV4      = 3'd2,
        REASON_BAD_IHL       = 3'd3,
        REASON_NOT_L4        = 3'd4,
        REASON_PORT_MISMATCH = 3'd5
    } reason_t;

    // One verdict word
    typedef struct packed {
        logic                redirect;
        logic [QUEUE_W-1:0]  target_queue;
        reason_t             reason;
    } verdict_t;

endpackage

`default_nettype wire

// ----- rtl/l4pc_frame_if.sv -----
// Valid/ready channel carrying one frame byte per word.
`default_nettype none

interface l4pc_frame_if;
    logic                           valid;
    logic                           ready;
    logic [l4pc_pkg::BYTE_W-1:0]    frame_byte;
    logic                           frame_end;
    logic [l4pc_pkg::QUEUE_W-1:0]   rx_queue;

    modport source (output valid, output frame_byte, output frame_end, output rx_queue,
                    input ready);
    modport sink   (input valid, input frame_byte, input frame_end, input rx_queue,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/l4pc_verdict_if.sv -----
// Valid/ready channel carrying one classification verdict per word.
`default_nettype none

interface l4pc_verdict_if;
    logic                           valid;
    logic                           ready;
    logic                           redirect;
    logic [l4pc_pkg::QUEUE_W-1:0]   target_queue;
    logic [2:0]                     verdict_reason;

    modport source (output valid, output redirect, output target_queue,
                    output verdict_reason, input ready);
    modport sink   (input valid, input redirect, input target_queue,
                    input verdict_reason, output ready);
endinterface

`default_nettype wire

// ----- rtl/l4_port_packet_classifier_top.sv -----
// Top level of the L4 port packet classifier: byte-wise frame parse and port verdict.
// Throughput: one frame byte accepted every cycle while the verdict side keeps up.
// Output: a frame's verdict is registered as its last byte is accepted, into the
// output word, or into the skid word while the output word is held; the two words
// let bytes flow while one verdict waits; frame.ready drops only when both are held.
// Reset: rst_n clears parse state, empties both buffer words, sets match_port to 6380.
`default_nettype none

module l4_port_packet_classifier_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [l4pc_pkg::PORT_W-1:0]    cfg_wr_data,
    l4pc_frame_if.sink                          frame,
    l4pc_verdict_if.source                      verdict
);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [l4pc_pkg::PORT_W-1:0] match_port_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_port_reg <= l4pc_pkg::MATCH_PORT_RESET;
        end
        else if (cfg_wr_en)
        begin
            match_port_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Parse state: the header fields gathered so far in the current frame
    // ------------------------------------------------------------------
    logic [l4pc_pkg::OFFSET_W-1:0] offset_reg;
    logic                          vlan_reg;
    logic [15:0]                   ether_type_reg;
    logic [l4pc_pkg::WORDS_W-1:0]  ip_words_reg;
    logic [7:0]                    ip_proto_reg;
    logic [l4pc_pkg::PORT_W-1:0]   dest_port_reg;
    logic [l4pc_pkg::QUEUE_W-1:0]  frame_queue_reg;

    logic [l4pc_pkg::OFFSET_W-1:0] offset_next;
    logic                          vlan_next;
    logic [15:0]                   ether_type_next;
    logic [l4pc_pkg::WORDS_W-1:0]  ip_words_next;
    logic [7:0]                    ip_proto_next;
    logic [l4pc_pkg::PORT_W-1:0]   dest_port_next;
    logic [l4pc_pkg::QUEUE_W-1:0]  frame_queue_next;

    logic                          frame_fire;
    logic                          type_shift;
    logic [l4pc_pkg::LEN_W-1:0]    pos_wide;
    logic [l4pc_pkg::LEN_W-1:0]    ip_base;
    logic [l4pc_pkg::LEN_W-1:0]    l4_start;
    logic [l4pc_pkg::LEN_W-1:0]    frame_len;
    logic [l4pc_pkg::LEN_W-1:0]    l4_need;
    l4pc_pkg::reason_t             reason;
    l4pc_pkg::verdict_t            verdict_new;

    assign frame_fire = frame.valid && frame.ready;
    assign pos_wide   = {1'b0, offset_reg};

    // Field capture: each header field is taken from the byte at its fixed offset,
    // with the IP and L4 offsets sliding behind an optional tag and IP options.
    always_comb
    begin
        frame_queue_next = (offset_reg == '0) ? frame.rx_queue : frame_queue_reg;

        type_shift = (offset_reg == l4pc_pkg::POS_TYPE_HI)
                  || (offset_reg == l4pc_pkg::POS_TYPE_LO)
                  || (vlan_reg && ((offset_reg == l4pc_pkg::POS_TAG_TYPE_HI)
                                || (offset_reg == l4pc_pkg::POS_TAG_TYPE_LO)));
        ether_type_next = type_shift ? {ether_type_reg[7:0], frame.frame_byte}
                                     : ether_type_reg;

        // The tag decision uses the outer EtherType just completed on this byte
        if (offset_reg == l4pc_pkg::POS_TYPE_LO)
        begin
            vlan_next = (ether_type_next == l4pc_pkg::TYPE_CTAG)
                     || (ether_type_next == l4pc_pkg::TYPE_STAG);
        end
        else
        begin
            vlan_next = vlan_reg;
        end

        ip_base = vlan_next ? l4pc_pkg::TAGGED_HDR_LEN : l4pc_pkg::ETH_HDR_LEN;

        ip_words_next = (pos_wide == ip_base) ? frame.frame_byte[l4pc_pkg::WORDS_W-1:0]
                                              : ip_words_reg;
        ip_proto_next = (pos_wide == ip_base + l4pc_pkg::IP_PROTO_POS) ? frame.frame_byte
                                                                       : ip_proto_reg;

        // L4 header starts after the IP header length in 32-bit words
        l4_start = ip_base + {2'b00, ip_words_next, 2'b00};

        if ((pos_wide == l4_start + l4pc_pkg::DPORT_POS_HI)
            || (pos_wide == l4_start + l4pc_pkg::DPORT_POS_LO))
        begin
            dest_port_next = {dest_port_reg[7:0], frame.frame_byte};
        end
        else
        begin
            dest_port_next = dest_port_reg;
        end

        offset_next = (offset_reg < l4pc_pkg::OFFSET_MAX)
                    ? offset_reg + l4pc_pkg::OFFSET_W'(1) : l4pc_pkg::OFFSET_MAX;
    end

    // Verdict: checks in header order, the first failing one sets the reason
    always_comb
    begin
        frame_len = pos_wide + l4pc_pkg::LEN_W'(1);
        l4_need   = l4pc_pkg::UDP_HDR_LEN;
        reason    = l4pc_pkg::REASON_MATCH;

        if (ip_proto_next == l4pc_pkg::PROTO_TCP)
        begin
            l4_need = l4pc_pkg::TCP_HDR_LEN;
        end

        if (frame_len < l4pc_pkg::ETH_HDR_LEN)
        begin
            reason = l4pc_pkg::REASON_TRUNCATED;
        end
        else if (vlan_next && (frame_len < l4pc_pkg::TAGGED_HDR_LEN))
        begin
            reason = l4pc_pkg::REASON_TRUNCATED;
        end
        else if (ether_type_next != l4pc_pkg::TYPE_IPV4)
        begin
            reason = l4pc_pkg::REASON_NOT_IPV4;
        end
        else if (frame_len < ip_base + l4pc_pkg::IP_HDR_LEN)
        begin
            reason = l4pc_pkg::REASON_TRUNCATED;
        end
        else if (ip_words_next < l4pc_pkg::IP_WORDS_MIN)
        begin
            reason = l4pc_pkg::REASON_BAD_IHL;
        end
        else if (l4_start > frame_len)
        begin
            reason = l4pc_pkg::REASON_TRUNCATED;
        end
        else if ((ip_proto_next != l4pc_pkg::PROTO_UDP)
                 && (ip_proto_next != l4pc_pkg::PROTO_TCP))
        begin
            reason = l4pc_pkg::REASON_NOT_L4;
        end
        else if (l4_start + l4_need > frame_len)
        begin
            reason = l4pc_pkg::REASON_TRUNCATED;
        end
        else if (dest_port_next != match_port_reg)
        begin
            reason = l4pc_pkg::REASON_PORT_MISMATCH;
        end

        // A matched frame on a queue without a socket keeps its queue but passes
        verdict_new.reason       = reason;
        verdict_new.redirect     = (reason == l4pc_pkg::REASON_MATCH)
                                && (int'(frame_queue_next) < l4pc_pkg::QUEUE_COUNT);
        verdict_new.target_queue = (reason == l4pc_pkg::REASON_MATCH) ? frame_queue_next
                                                                      : '0;
    end

    // Advance the parse state per byte; drop it all after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg      <= '0;
            vlan_reg        <= 1'b0;
            ether_type_reg  <= '0;
            ip_words_reg    <= '0;
            ip_proto_reg    <= '0;
            dest_port_reg   <= '0;
            frame_queue_reg <= '0;
        end
        else if (frame_fire)
        begin
            if (frame.frame_end)
            begin
                offset_reg      <= '0;
                vlan_reg        <= 1'b0;
                ether_type_reg  <= '0;
                ip_words_reg    <= '0;
                ip_proto_reg    <= '0;
                dest_port_reg   <= '0;
                frame_queue_reg <= '0;
            end
            else
            begin
                offset_reg      <= offset_next;
                vlan_reg        <= vlan_next;
                ether_type_reg  <= ether_type_next;
                ip_words_reg    <= ip_words_next;
                ip_proto_reg    <= ip_proto_next;
                dest_port_reg   <= dest_port_next;
                frame_queue_reg <= frame_queue_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output buffer: output register with a skid word behind it
    // ------------------------------------------------------------------
    logic               out_valid_reg;
    logic               skid_valid_reg;
    l4pc_pkg::verdict_t out_data_reg;
    l4pc_pkg::verdict_t skid_data_reg;
    logic               push;
    logic               pop;

    assign push = frame_fire && frame.frame_end;
    assign pop  = out_valid_reg && verdict.ready;

    // Bytes stall only when both buffer words hold a verdict
    assign frame.ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            // Output word is free: refill from skid first, else from the new verdict
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= push;
            end
            else
            begin
                out_valid_reg  <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg  <= skid_data_reg;
                skid_data_reg <= verdict_new;
            end
            else
            begin
                out_data_reg  <= verdict_new;
            end
        end
        else if (push)
        begin
            skid_data_reg <= verdict_new;
        end
    end

    assign verdict.valid          = out_valid_reg;
    assign verdict.redirect       = out_data_reg.redirect;
    assign verdict.target_queue   = out_data_reg.target_queue;
    assign verdict.verdict_reason = out_data_reg.reason;

`ifndef SYNTHESIS
    // The skid word is only ever filled behind a held output word
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word valid while output word empty");

    // A last byte always restarts the parse at offset zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (frame_fire && frame.frame_end) |=> (offset_reg == '0))
        else $error("byte offset not cleared after last byte");

    // Redirect only on a matched port
    assert property (@(posedge clk) disable iff (!rst_n)
        (verdict.valid && verdict.redirect)
            |-> (verdict.verdict_reason == l4pc_pkg::REASON_MATCH))
        else $error("redirect without port match");

    // A pass for any reason but a match carries queue zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (verdict.valid && (verdict.verdict_reason != l4pc_pkg::REASON_MATCH))
            |-> (verdict.target_queue == '0))
        else $error("non-zero queue on a pass verdict");

    // A verdict word is accepted only on a last byte, so a full buffer held without a
    // pop stays full in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !verdict.ready) |=> skid_valid_reg)
        else $error("skid word lost while stalled");
`endif

endmodule

`default_nettype wire

// ----- test/tb_l4_port_packet_classifier_top.sv -----
// Self-checking testbench for the L4 port packet classifier: frames in, port verdicts checked.
`timescale 1ns / 100ps

module tb_l4_port_packet_classifier_top;
    import l4pc_pkg::*;

    // Clock period, the run's cycle budget and the settle time after the last verdict
    localparam int CLK_PERIOD   = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int IDLE_PCT     = 15;
    localparam int RANDOM_FRAMES = 4;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [PORT_W-1:0]    cfg_wr_data;

    l4pc_frame_if   frame_ch ();
    l4pc_verdict_if verdict_ch ();

    l4_port_packet_classifier_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .frame       (frame_ch),
        .verdict     (verdict_ch)
    );

    // Verdicts worked out for accepted last bytes, oldest first
    verdict_t verdicts_due[$];
    // Bytes of the frame about to be sent
    logic [BYTE_W-1:0] frame_buf[$];

    // Mirror of the block's parse state and its match port register
    logic [OFFSET_W-1:0] offset_now;
    logic                tagged_now;
    logic [15:0]         type_now;
    logic [WORDS_W-1:0]  ihl_now;
    logic [7:0]          proto_now;
    logic [PORT_W-1:0]   dport_now;
    logic [QUEUE_W-1:0]  queue_now;
    logic [PORT_W-1:0]   port_sel;

    int       errors;
    int       cycle_count;
    bit       quiet;
    verdict_t want;

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog: drop the run once it runs past its cycle budget
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Verdict side: stall now and then, except during the quiet stretch
    always @(negedge clk)
    begin
        verdict_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // Check each accepted verdict word against the oldest one due
    always @(posedge clk)
    begin
        if (rst_n && verdict_ch.valid && verdict_ch.ready)
        begin
            if (verdicts_due.size() == 0)
            begin
                $error("verdict word with none due: redirect %0b queue %0d reason %0d",
                       verdict_ch.redirect, verdict_ch.target_queue, verdict_ch.verdict_reason);
                errors++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (verdict_ch.redirect !== want.redirect)
                begin
                    $error("redirect: expected %0b, got %0b", want.redirect, verdict_ch.redirect);
                    errors++;
                end
                if (verdict_ch.target_queue !== want.target_queue)
                begin
                    $error("target_queue: expected %0d, got %0d",
                           want.target_queue, verdict_ch.target_queue);
                    errors++;
                end
                if (verdict_ch.verdict_reason !== want.reason)
                begin
                    $error("verdict_reason: expected %0d, got %0d",
                           want.reason, verdict_ch.verdict_reason);
                    errors++;
                end
            end
        end
    end

    // One random frame byte
    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(255));
    endfunction

    // Forget everything about the frame once its verdict is out
    function automatic void clear_parse();
        offset_now = '0;
        tagged_now = 1'b0;
        type_now   = '0;
        ihl_now    = '0;
        proto_now  = '0;
        dport_now  = '0;
        queue_now  = '0;
    endfunction

    // Run the header checks in order on a frame of len bytes; the first that fails decides
    function automatic reason_t judge_frame(int len);
        int base;
        int l4;
        int need;
        if (len < int'(ETH_HDR_LEN))
            return REASON_TRUNCATED;
        if (tagged_now && len < int'(TAGGED_HDR_LEN))
            return REASON_TRUNCATED;
        if (type_now != TYPE_IPV4)
            return REASON_NOT_IPV4;
        base = tagged_now ? int'(TAGGED_HDR_LEN) : int'(ETH_HDR_LEN);
        if (len < base + int'(IP_HDR_LEN))
            return REASON_TRUNCATED;
        if (ihl_now < IP_WORDS_MIN)
            return REASON_BAD_IHL;
        l4 = base + int'(ihl_now) * 4;
        if (l4 > len)
            return REASON_TRUNCATED;
        if (proto_now == PROTO_UDP)
            need = int'(UDP_HDR_LEN);
        else if (proto_now == PROTO_TCP)
            need = int'(TCP_HDR_LEN);
        else
            return REASON_NOT_L4;
        if (l4 + need > len)
            return REASON_TRUNCATED;
        if (dport_now != port_sel)
            return REASON_PORT_MISMATCH;
        return REASON_MATCH;
    endfunction

    // Advance the parse by one accepted byte; on the last byte queue up the verdict
    task automatic classify_byte(input logic [BYTE_W-1:0] b, input logic last,
                                 input logic [QUEUE_W-1:0] q);
        int       pos;
        int       base;
        int       l4;
        reason_t  why;
        verdict_t v;
        pos = int'(offset_now);
        if (pos == 0)
            queue_now = q;
        // EtherType shifts in at 12/13, and again at 16/17 behind a tag
        if (pos == int'(POS_TYPE_HI) || pos == int'(POS_TYPE_LO) ||
            (tagged_now && (pos == int'(POS_TAG_TYPE_HI) || pos == int'(POS_TAG_TYPE_LO))))
            type_now = {type_now[7:0], b};
        if (pos == int'(POS_TYPE_LO))
            tagged_now = (type_now == TYPE_CTAG) || (type_now == TYPE_STAG);
        base = tagged_now ? int'(TAGGED_HDR_LEN) : int'(ETH_HDR_LEN);
        if (pos == base)
            ihl_now = b[WORDS_W-1:0];
        if (pos == base + int'(IP_PROTO_POS))
            proto_now = b;
        // Port bytes follow the IP header, options included
        l4 = base + int'(ihl_now) * 4;
        if (pos == l4 + int'(DPORT_POS_HI) || pos == l4 + int'(DPORT_POS_LO))
            dport_now = {dport_now[7:0], b};
        if (!last)
        begin
            offset_now = (offset_now < OFFSET_MAX) ? offset_now + 1'b1 : OFFSET_MAX;
            return;
        end
        why = judge_frame(pos + 1);
        v.redirect     = (why == REASON_MATCH) && (int'(queue_now) < QUEUE_COUNT);
        v.target_queue = (why == REASON_MATCH) ? queue_now : '0;
        v.reason       = why;
        verdicts_due.push_back(v);
        clear_parse();
    endtask

    // Offer one byte word; hold it until accepted, then predict. Enter and leave at negedge.
    task automatic send_word(input logic [BYTE_W-1:0] b, input logic last,
                             input logic [QUEUE_W-1:0] q);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            frame_ch.valid      <= 1'b0;
            frame_ch.frame_byte <= rand_byte();
            frame_ch.frame_end  <= 1'($urandom_range(1));
            @(negedge clk);
        end
        frame_ch.valid      <= 1'b1;
        frame_ch.frame_byte <= b;
        frame_ch.frame_end  <= last;
        frame_ch.rx_queue   <= q;
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
        classify_byte(b, last, q);
        @(negedge clk);
    endtask

    // Send frame_buf; queue q goes with the first byte, later bytes carry junk queues
    task automatic send_frame(input logic [QUEUE_W-1:0] q);
        for (int i = 0; i < frame_buf.size(); i++)
            send_word(frame_buf[i], i == frame_buf.size() - 1,
                      (i == 0) ? q : QUEUE_W'($urandom_range(63)));
    endtask

    // Assemble a frame: optional tag, EtherType, IP header with options, L4 header,
    // payload; then cut it to cut bytes if cut is non-zero
    task automatic build_frame(input logic [15:0] tag, input logic [15:0] etype,
                               input logic [WORDS_W-1:0] ihl, input logic [7:0] proto,
                               input logic [PORT_W-1:0] dport, input int extra, input int cut);
        frame_buf.delete();
        repeat (12) frame_buf.push_back(rand_byte());
        if (tag != 16'h0000)
        begin
            frame_buf.push_back(tag[15:8]);
            frame_buf.push_back(tag[7:0]);
            repeat (2) frame_buf.push_back(rand_byte());
        end
        frame_buf.push_back(etype[15:8]);
        frame_buf.push_back(etype[7:0]);
        // Version nibble is left random: the block ignores it
        frame_buf.push_back({4'($urandom_range(15)), ihl});
        repeat (8) frame_buf.push_back(rand_byte());
        frame_buf.push_back(proto);
        repeat (10) frame_buf.push_back(rand_byte());
        if (ihl > IP_WORDS_MIN)
            repeat ((int'(ihl) - 5) * 4) frame_buf.push_back(rand_byte());
        repeat (2) frame_buf.push_back(rand_byte());
        frame_buf.push_back(dport[15:8]);
        frame_buf.push_back(dport[7:0]);
        repeat ((proto == PROTO_UDP) ? 4 : 16) frame_buf.push_back(rand_byte());
        repeat (extra) frame_buf.push_back(rand_byte());
        if (cut > 0)
            while (frame_buf.size() > cut)
                void'(frame_buf.pop_back());
    endtask

    task automatic classify_frame(input logic [15:0] tag, input logic [15:0] etype,
                                  input logic [WORDS_W-1:0] ihl, input logic [7:0] proto,
                                  input logic [PORT_W-1:0] dport, input int extra,
                                  input int cut, input logic [QUEUE_W-1:0] q);
        build_frame(tag, etype, ihl, proto, dport, extra, cut);
        send_frame(q);
    endtask

    // Hold the frame side until every verdict due has arrived, then let the block settle
    task automatic drain_verdicts();
        frame_ch.valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write the match port with the block idle and at a frame boundary
    task automatic write_match_port(input logic [PORT_W-1:0] value);
        drain_verdicts();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        port_sel = value;
    endtask

    // Matches at the reset port: plain, both tag kinds, both protocols, edge queues
    task automatic test_reset_port_match();
        // Exact fit: UDP header ends on the last byte
        classify_frame(16'h0000, TYPE_IPV4, 4'd5, PROTO_UDP, port_sel, 0, 0, 6'd0);
        classify_frame(16'h0000, TYPE_IPV4, 4'd5, PROTO_TCP, port_sel, 0, 0, 6'd63);
        classify_frame(TYPE_CTAG, TYPE_IPV4, 4'd5, PROTO_UDP, port_sel, 3, 0, 6'd21);
        classify_frame(TYPE_STAG, TYPE_IPV4, 4'd7, PROTO_TCP, port_sel, 0, 0, 6'd42);
    endtask

    // Each pass reason but a port mismatch, and truncation at every stage of the parse
    task automatic test_pass_reasons();
        classify_frame(16'h0000, TYPE_IPV4, 4'd5, PROTO_UDP, port_sel, 0, 1, 6'd9);
        classify_frame(16'h0000, TYPE_IPV4, 4'd5, PROTO_UDP, port_sel, 0, 13, 6'd9);
        classify_frame(TYPE_CTAG, TYPE_IPV4, 4'd5, PROTO_UDP, port_sel, 0, 17, 6'd9);
        classify_frame(16'h0000, TYPE_IPV4, 4'd5, PROTO_UDP, port_sel, 0, 33, 6'd9);
        classify_frame(16'h0000, TYPE_IPV4, 4'd15, PROTO_UDP, port_sel, 0, 40, 6'd9);
        classify_frame(16'h0000, TYPE_IPV4, 4'd5, PROTO_UDP, port_sel, 0, 41, 6'd9);
        classify_frame(16'h0000, TYPE_IPV4, 4'd5, PROTO_TCP, port_sel, 0, 53, 6'd9);
        classify_frame(16'h0000, 16'h86DD, 4'd5, PROTO_UDP, port_sel, 0, 20, 6'd9);
        // Second tag in a row is not unwrapped
        classify_frame(TYPE_CTAG, TYPE_CTAG, 4'd5, PROTO_UDP, port_sel, 0, 20, 6'd9);
        classify_frame(16'h0000, TYPE_IPV4, 4'd0, PROTO_UDP, port_sel, 0, 34, 6'd9);
        classify_frame(TYPE_STAG, TYPE_IPV4, 4'd4, PROTO_TCP, port_sel, 0, 40, 6'd9);
        classify_frame(16'h0000, TYPE_IPV4, 4'd5, 8'd1, port_sel, 0, 36, 6'd9);
        // Frames of all zero and all one bytes
        frame_buf.delete();
        repeat (16) frame_buf.push_back(8'h00);
        send_frame(6'd0);
        frame_buf.delete();
        repeat (16) frame_buf.push_back(8'hFF);
        send_frame(6'd63);
    endtask

    // Offsets that reach and pass the saturation point, sent with no idling on either side
    task automatic test_long_frames();
        quiet = 1'b1;
        classify_frame(16'h0000, TYPE_IPV4, 4'd5, PROTO_UDP, port_sel, 86, 128, 6'd18);
        classify_frame(TYPE_CTAG, TYPE_IPV4, 4'd15, PROTO_TCP, port_sel ^ 16'h8000, 34, 0,
                       6'd19);
        quiet = 1'b0;
    endtask

    // Extreme port settings, each with a matching and a near-miss frame
    task automatic test_port_extremes();
        write_match_port(16'h0000);
        classify_frame(16'h0000, TYPE_IPV4, 4'd5, PROTO_UDP, 16'h0000, 2, 0, 6'd33);
        classify_frame(TYPE_STAG, TYPE_IPV4, 4'd5, PROTO_UDP, 16'h0100, 0, 0, 6'd34);
        write_match_port(16'hFFFF);
        classify_frame(16'h0000, TYPE_IPV4, 4'd6, PROTO_UDP, 16'hFFFF, 0, 0, 6'd35);
        classify_frame(TYPE_CTAG, TYPE_IPV4, 4'd5, PROTO_UDP, 16'hFFFE, 0, 0, 6'd36);
    endtask

    // One random frame: mostly well-formed with random content, some broken, some noise
    task automatic random_frame();
        int                 pick;
        logic [15:0]        tag;
        logic [15:0]        etype;
        logic [WORDS_W-1:0] ihl;
        logic [7:0]         proto;
        logic [PORT_W-1:0]  dport;
        int                 extra;
        int                 cut;
        pick = int'($urandom_range(99));
        if (pick < 8)
        begin
            frame_buf.delete();
            repeat ($urandom_range(90, 1)) frame_buf.push_back(rand_byte());
            send_frame(QUEUE_W'($urandom_range(63)));
            return;
        end
        pick  = int'($urandom_range(99));
        tag   = (pick < 60) ? 16'h0000 : (pick < 80) ? TYPE_CTAG : TYPE_STAG;
        etype = ($urandom_range(99) < 90) ? TYPE_IPV4 : 16'($urandom_range(65535));
        pick  = int'($urandom_range(99));
        ihl   = (pick < 80) ? 4'd5 : (pick < 95) ? 4'($urandom_range(15, 6))
                                                 : 4'($urandom_range(4));
        pick  = int'($urandom_range(99));
        proto = (pick < 45) ? PROTO_UDP : (pick < 90) ? PROTO_TCP : 8'($urandom_range(255));
        dport = ($urandom_range(99) < 50) ? port_sel : 16'($urandom_range(65535));
        extra = ($urandom_range(99) < 75) ? int'($urandom_range(8)) : int'($urandom_range(40));
        cut   = ($urandom_range(99) < 15) ? int'($urandom_range(70, 1)) : 0;
        classify_frame(tag, etype, ihl, proto, dport, extra, cut, QUEUE_W'($urandom_range(63)));
    endtask

    // Random traffic with a port change and a full pause part way through
    task automatic test_random_traffic();
        for (int n = 0; n < RANDOM_FRAMES; n++)
        begin
            if (n == 1)
                write_match_port(16'($urandom_range(65535)));
            if (n == 2)
                drain_verdicts();
            random_frame();
        end
    endtask

    initial
    begin
        errors      = 0;
        cycle_count = 0;
        quiet       = 1'b0;
        port_sel    = MATCH_PORT_RESET;
        clear_parse();
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_wr_data          = '0;
        frame_ch.valid       = 1'b0;
        frame_ch.frame_byte  = '0;
        frame_ch.frame_end   = 1'b0;
        frame_ch.rx_queue    = '0;
        verdict_ch.ready     = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_port_match();
        test_pass_reasons();
        test_long_frames();
        test_port_extremes();
        write_match_port(MATCH_PORT_RESET);
        test_random_traffic();

        drain_verdicts();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/l4pc_pkg.sv
rtl/l4pc_frame_if.sv
rtl/l4pc_verdict_if.sv
rtl/l4_port_packet_classifier_top.sv
test/tb_l4_port_packet_classifier_top.sv
